### rtl/complex_arithmetic_unit_top_assert.svh
// Assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// a implies b on the same edge
`define CAU_ASSERT_IMPL(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b on the next edge
`define CAU_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");

`endif

### rtl/cau_pkg.sv
// Types, codes and helper functions of the complex arithmetic unit
package cau_pkg;

  localparam int unsigned NUM_CELLS = 32;

  typedef enum logic [3:0] {
    OP_ADD_XY = 4'd0,
    OP_SUB_XY = 4'd1,
    OP_MUL_XY = 4'd2,
    OP_DIV_XY = 4'd3,
    OP_ADD_XA = 4'd4,
    OP_SUB_XA = 4'd5,
    OP_MUL_XA = 4'd6,
    OP_DIV_XA = 4'd7,
    OP_ADD_AY = 4'd8,
    OP_SUB_AY = 4'd9,
    OP_MUL_AY = 4'd10,
    OP_DIV_AY = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    MODE_ZERO  = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_SHIFT = 2'd2,
    MODE_DIV   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] x_real;
    logic signed [31:0] x_imag;
    logic signed [31:0] y_real;
    logic signed [31:0] y_imag;
    logic signed [31:0] scalar;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic               undefined;
    logic               saturated;
  } out_item_t;

  // products and decode after the multiplier stage
  typedef struct packed {
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic               sub_re;
    logic               sub_im;
    logic [63:0]        sq0;
    logic [63:0]        sq1;
    logic [31:0]        amag;
    logic               by_scalar;
    mode_e              mode;
  } prod_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [63:0] r;
    logic [31:0] bits;
    logic [31:0] q;
    logic        neg;
    logic        ovf;
  } lane_t;

  typedef struct packed {
    logic      is_div;
    logic [63:0] d;
    lane_t     re;
    lane_t     im;
    out_item_t pre;
  } cell_t;

  // returns {clipped, value}
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > 66'sd2147483647) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  // signed result from quotient magnitude; ovf means quotient >= 2^32
  function automatic logic [32:0] qsat(input logic neg, input logic ovf,
                                       input logic [31:0] q);
    logic [32:0] res;
    if (!neg) begin
      if (ovf || q[31]) res = {1'b1, 32'h7FFF_FFFF};
      else              res = {1'b0, q};
    end else begin
      if (ovf || (q > 32'h8000_0000)) res = {1'b1, 32'h8000_0000};
      else                            res = {1'b0, 32'd0 - q};
    end
    return res;
  endfunction

endpackage

### rtl/complex_arithmetic_unit_top.sv
// Complex arithmetic unit: Q16.16 add, subtract, multiply and divide
//
// Input channel in_valid_i/in_ready_o carries one operand set and opcode per
// item; output channel out_valid_o/out_ready_i carries one result per item.
// Results come out in order. An accepted item passes through a multiplier
// stage, a sum stage, 32 divider cells (one quotient bit each, both parts in
// parallel) and the output register. Every opcode takes the same path, so
// throughput is one item per cycle when the output is not stalled.
// Each pipeline stage advances when it is empty or when the stage behind it
// advances, so bubbles close up and a new item is taken while a finished
// result waits at the output. A stalled receiver fills the pipe; in_ready_o
// drops only when every stage holds an item.
// Reset clears all valid flags; no items are in flight afterwards.
`include "complex_arithmetic_unit_top_assert.svh"

module complex_arithmetic_unit_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cau_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cau_pkg::out_item_t  out_item_o
);

  localparam int unsigned N = cau_pkg::NUM_CELLS;

  logic               en1, en2, v1, v2, out_en;
  logic [N-1:0]       cell_en, cell_v;
  logic [N:0]         cell_vin;
  cau_pkg::cell_t     cell_in [N+1];

  assign out_en   = !out_valid_o || out_ready_i;
  assign cell_vin = {cell_v, v2};

  for (genvar k = 0; k < N; k++) begin : g_en
    if (k == N - 1) begin : g_last
      assign cell_en[k] = !cell_v[k] || out_en;
    end else begin : g_mid
      assign cell_en[k] = !cell_v[k] || cell_en[k+1];
    end
  end

  assign en2        = !v2 || cell_en[0];
  assign en1        = !v1 || en2;
  assign in_ready_o = en1;

  cau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en1_i      (en1),
    .en2_i      (en2),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .v1_o       (v1),
    .v2_o       (v2),
    .cell_o     (cell_in[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    cau_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (cell_en[k]),
      .valid_i (cell_vin[k]),
      .cell_i  (cell_in[k]),
      .valid_o (cell_v[k]),
      .cell_o  (cell_in[k+1])
    );
  end

  cau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (out_en),
    .valid_i     (cell_v[N-1]),
    .cell_i      (cell_in[N]),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // backpressure reaches the input only with a full pipe and a stalled output
  `CAU_ASSERT_IMPL(a_full_when_blocked, clk_i, rst_ni, !in_ready_o,
    out_valid_o && !out_ready_i && v1 && v2 && (&cell_v))
  `CAU_ASSERT_IMPL(a_undef_zero, clk_i, rst_ni, out_valid_o && out_item_o.undefined,
    !out_item_o.saturated && out_item_o.result_real == 0 && out_item_o.result_imag == 0)
  `CAU_ASSERT_IMPL(a_sat_extreme, clk_i, rst_ni, out_valid_o && out_item_o.saturated,
    out_item_o.result_real == 32'sh7FFF_FFFF || out_item_o.result_real == 32'sh8000_0000 ||
    out_item_o.result_imag == 32'sh7FFF_FFFF || out_item_o.result_imag == 32'sh8000_0000)
  `CAU_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_item_o))

endmodule

### rtl/cau_front.sv
// Operand select, multipliers and sum stage ahead of the divider chain
module cau_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en1_i,
  input  logic                en2_i,
  input  logic                in_valid_i,
  input  cau_pkg::in_item_t   in_item_i,
  output logic                v1_o,
  output logic                v2_o,
  output cau_pkg::cell_t      cell_o
);

  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];
  logic signed [63:0] prod [6];
  logic               sub_re, sub_im, by_scalar;
  cau_pkg::mode_e     mode;
  logic [31:0]        amag;
  cau_pkg::prod_t     s1_d, s1_q;
  cau_pkg::cell_t     s2_d, s2_q;
  logic               v1_q, v2_q;

  logic signed [31:0] xr, xi, yr, yi, sa;
  assign xr = in_item_i.x_real;
  assign xi = in_item_i.x_imag;
  assign yr = in_item_i.y_real;
  assign yi = in_item_i.y_imag;
  assign sa = in_item_i.scalar;

  // real = p0 +/- p1, imag = p2 +/- p3; sums pass through a multiply by one
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    sub_re    = 1'b0;
    sub_im    = 1'b0;
    by_scalar = 1'b0;
    mode      = cau_pkg::MODE_ZERO;
    ma[4] = yr; mb[4] = yr;
    ma[5] = yi; mb[5] = yi;
    case (in_item_i.operation)
      cau_pkg::OP_ADD_XY, cau_pkg::OP_SUB_XY: begin
        mode = cau_pkg::MODE_ADD;
        ma[0] = xr; mb[0] = 32'sd1; ma[1] = yr; mb[1] = 32'sd1;
        ma[2] = xi; mb[2] = 32'sd1; ma[3] = yi; mb[3] = 32'sd1;
        sub_re = (in_item_i.operation == cau_pkg::OP_SUB_XY);
        sub_im = sub_re;
      end
      cau_pkg::OP_MUL_XY: begin
        mode = cau_pkg::MODE_SHIFT;
        ma[0] = xr; mb[0] = yr; ma[1] = xi; mb[1] = yi; sub_re = 1'b1;
        ma[2] = xr; mb[2] = yi; ma[3] = xi; mb[3] = yr;
      end
      cau_pkg::OP_DIV_XY: begin
        mode = cau_pkg::MODE_DIV;
        ma[0] = xr; mb[0] = yr; ma[1] = xi; mb[1] = yi;
        ma[2] = xi; mb[2] = yr; ma[3] = xr; mb[3] = yi; sub_im = 1'b1;
      end
      cau_pkg::OP_ADD_XA, cau_pkg::OP_SUB_XA: begin
        mode = cau_pkg::MODE_ADD;
        ma[0] = xr; mb[0] = 32'sd1; ma[1] = sa; mb[1] = 32'sd1;
        ma[2] = xi; mb[2] = 32'sd1;
        sub_re = (in_item_i.operation == cau_pkg::OP_SUB_XA);
      end
      cau_pkg::OP_MUL_XA: begin
        mode = cau_pkg::MODE_SHIFT;
        ma[0] = xr; mb[0] = sa; ma[2] = xi; mb[2] = sa;
      end
      cau_pkg::OP_DIV_XA: begin
        mode = cau_pkg::MODE_DIV;
        by_scalar = 1'b1;
        // sign of the scalar folded into the numerators, divisor is |a|
        ma[0] = xr; mb[0] = sa[31] ? -32'sd1 : 32'sd1;
        ma[2] = xi; mb[2] = sa[31] ? -32'sd1 : 32'sd1;
      end
      cau_pkg::OP_ADD_AY, cau_pkg::OP_SUB_AY: begin
        mode = cau_pkg::MODE_ADD;
        ma[0] = sa; mb[0] = 32'sd1; ma[1] = yr; mb[1] = 32'sd1;
        ma[3] = yi; mb[3] = 32'sd1;
        sub_re = (in_item_i.operation == cau_pkg::OP_SUB_AY);
        sub_im = sub_re;
      end
      cau_pkg::OP_MUL_AY: begin
        mode = cau_pkg::MODE_SHIFT;
        ma[0] = sa; mb[0] = yr; ma[2] = sa; mb[2] = yi;
      end
      cau_pkg::OP_DIV_AY: begin
        mode = cau_pkg::MODE_DIV;
        ma[0] = sa; mb[0] = yr; ma[3] = sa; mb[3] = yi; sub_im = 1'b1;
      end
      default: begin
        mode = cau_pkg::MODE_ZERO;
      end
    endcase
  end

  for (genvar k = 0; k < 6; k++) begin : g_mul
    assign prod[k] = ma[k] * mb[k];
  end

  assign amag = sa[31] ? (32'd0 - sa) : sa;

  always_comb begin
    s1_d.p0        = prod[0];
    s1_d.p1        = prod[1];
    s1_d.p2        = prod[2];
    s1_d.p3        = prod[3];
    s1_d.sub_re    = sub_re;
    s1_d.sub_im    = sub_im;
    s1_d.sq0       = prod[4];
    s1_d.sq1       = prod[5];
    s1_d.amag      = amag;
    s1_d.by_scalar = by_scalar;
    s1_d.mode      = mode;
  end

  // sum stage
  logic signed [65:0] re, im;
  logic [65:0]        re_abs, im_abs;
  logic [63:0]        dvs, re_mag, im_mag;
  logic [32:0]        sre, sim;

  always_comb begin
    re = s1_q.sub_re ? (66'(s1_q.p0) - 66'(s1_q.p1)) : (66'(s1_q.p0) + 66'(s1_q.p1));
    im = s1_q.sub_im ? (66'(s1_q.p2) - 66'(s1_q.p3)) : (66'(s1_q.p2) + 66'(s1_q.p3));
    re_abs = re[65] ? (66'd0 - re) : re;
    im_abs = im[65] ? (66'd0 - im) : im;
    re_mag = re_abs[63:0];
    im_mag = im_abs[63:0];
    dvs = s1_q.by_scalar ? 64'(s1_q.amag) : (s1_q.sq0 + s1_q.sq1);
    if (s1_q.mode == cau_pkg::MODE_SHIFT) begin
      sre = cau_pkg::sat32(re >>> 16);
      sim = cau_pkg::sat32(im >>> 16);
    end else begin
      sre = cau_pkg::sat32(re);
      sim = cau_pkg::sat32(im);
    end

    s2_d.is_div  = (s1_q.mode == cau_pkg::MODE_DIV);
    s2_d.d       = dvs;
    s2_d.re.r    = {16'd0, re_mag[63:16]};
    s2_d.re.bits = {re_mag[15:0], 16'd0};
    s2_d.re.q    = '0;
    s2_d.re.neg  = re[65];
    s2_d.re.ovf  = ({16'd0, re_mag} >= {dvs, 16'd0});
    s2_d.im.r    = {16'd0, im_mag[63:16]};
    s2_d.im.bits = {im_mag[15:0], 16'd0};
    s2_d.im.q    = '0;
    s2_d.im.neg  = im[65];
    s2_d.im.ovf  = ({16'd0, im_mag} >= {dvs, 16'd0});

    s2_d.pre = '0;
    case (s1_q.mode)
      cau_pkg::MODE_ADD, cau_pkg::MODE_SHIFT: begin
        s2_d.pre.result_real = sre[31:0];
        s2_d.pre.result_imag = sim[31:0];
        s2_d.pre.saturated   = sre[32] | sim[32];
      end
      cau_pkg::MODE_DIV: begin
        s2_d.pre.undefined = (dvs == 64'd0);
      end
      default: begin
        s2_d.pre = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1_i) v1_q <= in_valid_i;
      if (en2_i) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) s1_q <= s1_d;
    if (en2_i) s2_q <= s2_d;
  end

  assign v1_o   = v1_q;
  assign v2_o   = v2_q;
  assign cell_o = s2_q;

endmodule

### rtl/cau_cell.sv
// One divider cell: retires one quotient bit per lane and hands the item on
module cau_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cau_pkg::cell_t cell_i,
  output logic           valid_o,
  output cau_pkg::cell_t cell_o
);

  function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l, input logic [63:0] d);
    cau_pkg::lane_t n;
    logic [63:0]    t;
    n = l;
    t = {l.r[62:0], l.bits[31]};
    n.bits = {l.bits[30:0], 1'b0};
    if (t >= d) begin
      n.r = t - d;
      n.q = {l.q[30:0], 1'b1};
    end else begin
      n.r = t;
      n.q = {l.q[30:0], 1'b0};
    end
    return n;
  endfunction

  cau_pkg::cell_t cell_d, cell_q;
  logic           valid_q;

  always_comb begin
    cell_d    = cell_i;
    cell_d.re = step(cell_i.re, cell_i.d);
    cell_d.im = step(cell_i.im, cell_i.d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

### rtl/cau_back.sv
// Quotient saturation and output register
module cau_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  cau_pkg::cell_t      cell_i,
  output logic                out_valid_o,
  output cau_pkg::out_item_t  out_item_o
);

  cau_pkg::out_item_t out_d, out_q;
  logic               valid_q;
  logic [32:0]        qre, qim;

  always_comb begin
    qre   = cau_pkg::qsat(cell_i.re.neg, cell_i.re.ovf, cell_i.re.q);
    qim   = cau_pkg::qsat(cell_i.im.neg, cell_i.im.ovf, cell_i.im.q);
    out_d = cell_i.pre;
    if (cell_i.is_div && !cell_i.pre.undefined) begin
      out_d.result_real = qre[31:0];
      out_d.result_imag = qim[31:0];
      out_d.saturated   = qre[32] | qim[32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = out_q;

endmodule

### tb/tb_complex_arithmetic_unit_top.sv
// Testbench for the complex arithmetic unit: directed and random items, scoreboard check
`timescale 1ns / 100ps

module tb_complex_arithmetic_unit_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_RANDOM  = 550;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam logic signed [127:0] Q_HI = 128'sd2147483647;
  localparam logic signed [127:0] Q_LO = -128'sd2147483648;

  class cx_scoreboard;
    cau_pkg::out_item_t expected_results[$];
    int unsigned fails = 0;

    // clip a wide value to Q16.16, noting a clip in f
    function automatic logic [31:0] clip(input logic signed [127:0] v, inout logic f);
      if (v > Q_HI) begin
        f = 1'b1;
        return 32'h7FFF_FFFF;
      end
      if (v < Q_LO) begin
        f = 1'b1;
        return 32'h8000_0000;
      end
      return v[31:0];
    endfunction

    // truncating Q16.16 quotient of magnitudes, sign applied afterwards
    function automatic logic signed [127:0] quot(input logic neg, input logic [127:0] mag,
                                                 input logic [127:0] d);
      logic [127:0] q;
      q = (mag << 16) / d;
      return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [127:0] absv(input logic signed [127:0] v);
      return (v < 0) ? -v : v;
    endfunction

    function automatic cau_pkg::out_item_t predict_complex(input cau_pkg::in_item_t it);
      cau_pkg::out_item_t r;
      logic signed [127:0] xr, xi, yr, yi, a, nr, ni;
      logic [127:0] d;
      logic f;
      xr = $signed(it.x_real);
      xi = $signed(it.x_imag);
      yr = $signed(it.y_real);
      yi = $signed(it.y_imag);
      a  = $signed(it.scalar);
      f = 1'b0;
      r = '0;
      case (it.operation)
        cau_pkg::OP_ADD_XY: begin
          r.result_real = clip(xr + yr, f);
          r.result_imag = clip(xi + yi, f);
        end
        cau_pkg::OP_SUB_XY: begin
          r.result_real = clip(xr - yr, f);
          r.result_imag = clip(xi - yi, f);
        end
        cau_pkg::OP_MUL_XY: begin
          r.result_real = clip((xr * yr - xi * yi) >>> 16, f);
          r.result_imag = clip((xr * yi + xi * yr) >>> 16, f);
        end
        cau_pkg::OP_DIV_XY, cau_pkg::OP_DIV_AY: begin
          d = yr * yr + yi * yi;
          if (d == 0) begin
            r.undefined = 1'b1;
          end else begin
            if (it.operation == cau_pkg::OP_DIV_XY) begin
              nr = xr * yr + xi * yi;
              ni = xi * yr - xr * yi;
            end else begin
              nr = a * yr;
              ni = -(a * yi);
            end
            r.result_real = clip(quot(nr < 0, absv(nr), d), f);
            r.result_imag = clip(quot(ni < 0, absv(ni), d), f);
          end
        end
        cau_pkg::OP_ADD_XA: begin
          r.result_real = clip(xr + a, f);
          r.result_imag = clip(xi, f);
        end
        cau_pkg::OP_SUB_XA: begin
          r.result_real = clip(xr - a, f);
          r.result_imag = clip(xi, f);
        end
        cau_pkg::OP_MUL_XA: begin
          r.result_real = clip((xr * a) >>> 16, f);
          r.result_imag = clip((xi * a) >>> 16, f);
        end
        cau_pkg::OP_DIV_XA: begin
          if (a == 0) begin
            r.undefined = 1'b1;
          end else begin
            r.result_real = clip(quot((xr < 0) != (a < 0), absv(xr), absv(a)), f);
            r.result_imag = clip(quot((xi < 0) != (a < 0), absv(xi), absv(a)), f);
          end
        end
        cau_pkg::OP_ADD_AY: begin
          r.result_real = clip(a + yr, f);
          r.result_imag = clip(yi, f);
        end
        cau_pkg::OP_SUB_AY: begin
          r.result_real = clip(a - yr, f);
          r.result_imag = clip(-yi, f);
        end
        cau_pkg::OP_MUL_AY: begin
          r.result_real = clip((a * yr) >>> 16, f);
          r.result_imag = clip((a * yi) >>> 16, f);
        end
        default: ;
      endcase
      r.saturated = r.undefined ? 1'b0 : f;
      if (r.undefined) begin
        r.result_real = '0;
        r.result_imag = '0;
      end
      return r;
    endfunction

    function void note_operands(input cau_pkg::in_item_t it);
      expected_results.push_back(predict_complex(it));
    endfunction

    function void check_result(input cau_pkg::out_item_t got);
      cau_pkg::out_item_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result with no item pending: %h", got);
        fails++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.result_real !== exp_r.result_real) begin
        $error("result_real expected %h actual %h", exp_r.result_real, got.result_real);
        fails++;
      end
      if (got.result_imag !== exp_r.result_imag) begin
        $error("result_imag expected %h actual %h", exp_r.result_imag, got.result_imag);
        fails++;
      end
      if (got.undefined !== exp_r.undefined) begin
        $error("undefined expected %b actual %b", exp_r.undefined, got.undefined);
        fails++;
      end
      if (got.saturated !== exp_r.saturated) begin
        $error("saturated expected %b actual %b", exp_r.saturated, got.saturated);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  cau_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  cau_pkg::out_item_t out_item_o;

  cx_scoreboard sb = new();
  int unsigned  cycles = 0;
  bit           long_hold_req = 1'b0;

  complex_arithmetic_unit_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_complex_arithmetic_unit_top NOT OK");
      $finish;
    end
  end

  // both monitors read pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_operands(in_item_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // receiver: stall mode is picked at random from four modes, plus one long hold
  int unsigned stall_mode = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (long_hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        2: out_ready_i <= ($urandom_range(0, 4) == 0);
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      1: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      2: begin
        case ($urandom_range(0, 6))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0001_0000;
          4: return 32'hFFFF_0000;
          5: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic cau_pkg::in_item_t rand_operands();
    cau_pkg::in_item_t it;
    it.operation = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                               : 4'($urandom_range(0, 11));
    it.x_real = rand_q();
    it.x_imag = rand_q();
    it.y_real = rand_q();
    it.y_imag = rand_q();
    it.scalar = rand_q();
    // zero divisors now and then
    if ($urandom_range(0, 9) == 0) begin
      if (it.operation == cau_pkg::OP_DIV_XA) it.scalar = '0;
      else begin
        it.y_real = '0;
        it.y_imag = '0;
      end
    end
    return it;
  endfunction

  task automatic send_item(input cau_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic idle_sender(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // let the clock tick first so the monitor has noted the last accepted item
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic cau_pkg::in_item_t mk(input logic [3:0] op, input logic [31:0] xr,
                                           input logic [31:0] xi, input logic [31:0] yr,
                                           input logic [31:0] yi, input logic [31:0] a);
    cau_pkg::in_item_t it;
    it = '{operation: op, x_real: xr, x_imag: xi, y_real: yr, y_imag: yi, scalar: a};
    return it;
  endfunction

  cau_pkg::in_item_t directed[$];
  int unsigned sent;
  int unsigned burst;

  initial begin
    directed.push_back(mk(cau_pkg::OP_ADD_XY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 0));
    directed.push_back(mk(cau_pkg::OP_SUB_XY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 0));
    directed.push_back(mk(cau_pkg::OP_MUL_XY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 0));
    directed.push_back(mk(cau_pkg::OP_MUL_XY, 32'h0002_0000, 32'hFFFF_8000, 32'hFFFF_FFFF,
                          32'h0001_0000, 0));
    directed.push_back(mk(cau_pkg::OP_DIV_XY, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000,
                          32'hFFFF_0000, 0));
    directed.push_back(mk(cau_pkg::OP_DIV_XY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    directed.push_back(mk(cau_pkg::OP_DIV_XY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                          0, 0));
    directed.push_back(mk(cau_pkg::OP_DIV_XY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 0));
    directed.push_back(mk(cau_pkg::OP_ADD_XA, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
                          32'h0000_0001));
    directed.push_back(mk(cau_pkg::OP_SUB_XA, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                          32'h0000_0001));
    directed.push_back(mk(cau_pkg::OP_MUL_XA, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
                          32'h7FFF_FFFF));
    directed.push_back(mk(cau_pkg::OP_MUL_XA, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0,
                          32'h0000_0001));
    directed.push_back(mk(cau_pkg::OP_DIV_XA, 32'h8000_0000, 32'h0001_0000, 0, 0,
                          32'hFFFF_0000));
    directed.push_back(mk(cau_pkg::OP_DIV_XA, 32'h0005_0000, 32'hFFFB_0000, 0, 0,
                          32'h0002_0000));
    directed.push_back(mk(cau_pkg::OP_DIV_XA, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    directed.push_back(mk(cau_pkg::OP_DIV_XA, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
                          32'h0000_0001));
    directed.push_back(mk(cau_pkg::OP_DIV_XA, 32'h0003_0000, 32'hFFFD_0000, 0, 0,
                          32'hFFFE_0000));
    directed.push_back(mk(cau_pkg::OP_ADD_AY, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF));
    directed.push_back(mk(cau_pkg::OP_SUB_AY, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0000));
    directed.push_back(mk(cau_pkg::OP_MUL_AY, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000));
    directed.push_back(mk(cau_pkg::OP_DIV_AY, 0, 0, 32'h0002_0000, 32'h0002_0000,
                          32'h0004_0000));
    directed.push_back(mk(cau_pkg::OP_DIV_AY, 0, 0, 0, 0, 32'h7FFF_FFFF));
    directed.push_back(mk(cau_pkg::OP_DIV_AY, 0, 0, 32'h0000_0001, 0, 32'h8000_0000));
    directed.push_back(mk(4'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(mk(4'd15, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F,
                          32'hF0F0_F0F0, 32'h5555_5555));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_item(directed[i]);
    // sender pauses until everything is back
    wait_drained();

    long_hold_req = 1'b1;
    sent = 0;
    while (sent < NUM_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int unsigned k = 0; k < burst && sent < NUM_RANDOM; k++) begin
        send_item(rand_operands());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
    end
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.fails == 0 && sb.expected_results.size() == 0) begin
      $display("tb_complex_arithmetic_unit_top OK");
    end else begin
      $display("tb_complex_arithmetic_unit_top NOT OK");
    end
    $finish;
  end

endmodule
